FILE: rtl/cec_pkg.sv
// Shared types, constants and tables of the calendar and epoch-seconds converter.
package cec_pkg;

    localparam logic [31:0] SEC_PER_DAY   = 32'd86400;
    localparam logic [31:0] SEC_PER_HOUR  = 32'd3600;
    localparam logic [31:0] SEC_PER_MIN   = 32'd60;
    localparam logic [31:0] DAYS_PER_WEEK = 32'd7;
    localparam logic [31:0] DAYS_LEAP     = 32'd366;
    localparam logic [31:0] DAYS_COMMON   = 32'd365;
    localparam logic [31:0] WEEK_OFFSET   = 32'd5;

    localparam logic [4:0] MUL_LAST     = 5'd14;
    localparam logic [4:0] DAY_BIT_TOP  = 5'd15;
    localparam logic [4:0] HOUR_BIT_TOP = 5'd4;
    localparam logic [4:0] MIN_BIT_TOP  = 5'd5;
    localparam logic [4:0] WEEK_BIT_TOP = 5'd13;
    localparam logic [3:0] LAST_MONTH   = 4'd12;

    typedef enum logic [1:0] {
        REQ_TO_SECONDS  = 2'd0,
        REQ_TO_FIELDS   = 2'd1,
        REQ_ADD_SECONDS = 2'd2,
        REQ_NONE        = 2'd3
    } t_req_code;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [5:0]  in_second;
        logic [5:0]  in_minute;
        logic [4:0]  in_hour;
        logic [4:0]  in_day_of_month;
        logic [3:0]  in_month;
        logic [7:0]  in_year;
        logic [31:0] in_seconds;
    } t_cec_req;

    typedef struct packed {
        logic [31:0] out_epoch_seconds;
        logic [5:0]  out_second;
        logic [5:0]  out_minute;
        logic [4:0]  out_hour;
        logic [2:0]  out_weekday;
        logic [4:0]  out_day_of_month;
        logic [3:0]  out_month;
        logic [7:0]  out_year;
    } t_cec_rsp;

    typedef struct packed {
        logic     done;
        t_cec_rsp rsp;
    } t_cec_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_E_DOM,
        S_E_YEAR,
        S_E_MONTH,
        S_E_MUL,
        S_D_DAY,
        S_D_HOUR,
        S_D_MIN,
        S_D_WOFF,
        S_D_WMOD,
        S_D_YEAR,
        S_D_MONTH,
        S_DONE
    } t_cec_state;

    typedef enum logic [2:0] {
        SRC_DAYS,
        SRC_HOUR,
        SRC_MIN,
        SRC_SEC,
        SRC_ADD
    } t_mul_src;

    typedef struct packed {
        t_mul_src   src;
        logic [4:0] shift;
    } t_mul_term;

    // seconds = days*86400 + hour*3600 + minute*60 + second (+ added seconds)
    function automatic t_mul_term mul_term(input logic [4:0] k);
        t_mul_term t;
        case (k)
            5'd0:    t = '{SRC_DAYS, 5'd16};
            5'd1:    t = '{SRC_DAYS, 5'd14};
            5'd2:    t = '{SRC_DAYS, 5'd12};
            5'd3:    t = '{SRC_DAYS, 5'd8};
            5'd4:    t = '{SRC_DAYS, 5'd7};
            5'd5:    t = '{SRC_HOUR, 5'd11};
            5'd6:    t = '{SRC_HOUR, 5'd10};
            5'd7:    t = '{SRC_HOUR, 5'd9};
            5'd8:    t = '{SRC_HOUR, 5'd4};
            5'd9:    t = '{SRC_MIN, 5'd5};
            5'd10:   t = '{SRC_MIN, 5'd4};
            5'd11:   t = '{SRC_MIN, 5'd3};
            5'd12:   t = '{SRC_MIN, 5'd2};
            5'd13:   t = '{SRC_SEC, 5'd0};
            default: t = '{SRC_ADD, 5'd0};
        endcase
        return t;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] mon, input logic [7:0] year);
        logic [4:0] d;
        case (mon)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                      d = 5'd30;
            4'd2:                                         d = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
            default:                                      d = 5'd0;
        endcase
        return d;
    endfunction

endpackage

FILE: rtl/cec_addsub.sv
// Shared 32-bit add, subtract and compare unit.
module cec_addsub import cec_pkg::*; (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic        i_sub,
    output logic [31:0] o_sum,
    output logic        o_borrow
);

    logic [32:0] w_full;

    assign w_full   = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)} + {32'd0, i_sub};
    assign o_sum    = w_full[31:0];
    assign o_borrow = i_sub & ~w_full[32];

endmodule

FILE: rtl/cec_engine.sv
// Sequencer and working registers that drive the shared add/subtract unit.
module cec_engine import cec_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  t_cec_req    i_req,
    output logic        o_busy,
    output t_cec_result o_result
);

    t_cec_state  r_state, n_state;
    logic [1:0]  r_req, n_req;
    logic [5:0]  r_in_sec, n_in_sec;
    logic [5:0]  r_in_min, n_in_min;
    logic [4:0]  r_in_hour, n_in_hour;
    logic [4:0]  r_in_dom, n_in_dom;
    logic [3:0]  r_in_mon, n_in_mon;
    logic [7:0]  r_in_year, n_in_year;
    logic [31:0] r_add, n_add;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_days, n_days;
    logic [31:0] r_secs, n_secs;
    logic [4:0]  r_k, n_k;
    logic [7:0]  r_cnt, n_cnt;
    logic [3:0]  r_mon, n_mon;
    logic [5:0]  r_out_sec, n_out_sec;
    logic [5:0]  r_out_min, n_out_min;
    logic [4:0]  r_out_hour, n_out_hour;

    logic [31:0] op_a, op_b, w_sum, w_src;
    logic        op_sub, w_borrow;
    t_mul_term   w_term;

    cec_addsub u_addsub (
        .i_a      (op_a),
        .i_b      (op_b),
        .i_sub    (op_sub),
        .o_sum    (w_sum),
        .o_borrow (w_borrow)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_req      <= n_req;
        r_in_sec   <= n_in_sec;
        r_in_min   <= n_in_min;
        r_in_hour  <= n_in_hour;
        r_in_dom   <= n_in_dom;
        r_in_mon   <= n_in_mon;
        r_in_year  <= n_in_year;
        r_add      <= n_add;
        r_acc      <= n_acc;
        r_days     <= n_days;
        r_secs     <= n_secs;
        r_k        <= n_k;
        r_cnt      <= n_cnt;
        r_mon      <= n_mon;
        r_out_sec  <= n_out_sec;
        r_out_min  <= n_out_min;
        r_out_hour <= n_out_hour;
    end

    always_comb begin
        w_term = mul_term(r_k);
        case (w_term.src)
            SRC_DAYS: w_src = r_days;
            SRC_HOUR: w_src = {27'd0, r_in_hour};
            SRC_MIN:  w_src = {26'd0, r_in_min};
            SRC_SEC:  w_src = {26'd0, r_in_sec};
            SRC_ADD:  w_src = (r_req == REQ_ADD_SECONDS) ? r_add : 32'd0;
            default:  w_src = 32'd0;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_in_sec   = r_in_sec;
        n_in_min   = r_in_min;
        n_in_hour  = r_in_hour;
        n_in_dom   = r_in_dom;
        n_in_mon   = r_in_mon;
        n_in_year  = r_in_year;
        n_add      = r_add;
        n_acc      = r_acc;
        n_days     = r_days;
        n_secs     = r_secs;
        n_k        = r_k;
        n_cnt      = r_cnt;
        n_mon      = r_mon;
        n_out_sec  = r_out_sec;
        n_out_min  = r_out_min;
        n_out_hour = r_out_hour;
        op_a       = r_acc;
        op_b       = 32'd0;
        op_sub     = 1'b0;
        o_result   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_take) begin
                    n_req     = i_req.req_type;
                    n_in_sec  = i_req.in_second;
                    n_in_min  = i_req.in_minute;
                    n_in_hour = i_req.in_hour;
                    n_in_dom  = i_req.in_day_of_month;
                    n_in_mon  = i_req.in_month;
                    n_in_year = i_req.in_year;
                    n_add     = i_req.in_seconds;
                    case (i_req.req_type)
                        REQ_TO_SECONDS, REQ_ADD_SECONDS: begin
                            n_acc   = 32'hFFFF_FFFF;
                            n_state = S_E_DOM;
                        end
                        REQ_TO_FIELDS: begin
                            n_acc      = i_req.in_seconds;
                            n_secs     = i_req.in_seconds;
                            n_days     = 32'd0;
                            n_out_hour = 5'd0;
                            n_out_min  = 6'd0;
                            n_k        = DAY_BIT_TOP;
                            n_state    = S_D_DAY;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_E_DOM: begin
                op_b    = {27'd0, r_in_dom};
                n_acc   = w_sum;
                n_cnt   = 8'd0;
                n_state = S_E_YEAR;
            end
            S_E_YEAR: begin
                op_b = (r_cnt[1:0] == 2'd0) ? DAYS_LEAP : DAYS_COMMON;
                if (r_cnt == r_in_year) begin
                    n_mon   = 4'd1;
                    n_state = S_E_MONTH;
                end else begin
                    n_acc = w_sum;
                    n_cnt = r_cnt + 8'd1;
                end
            end
            S_E_MONTH: begin
                op_b = {27'd0, month_days(r_mon, r_in_year)};
                if (r_mon >= r_in_mon) begin
                    n_days  = r_acc;
                    n_acc   = 32'd0;
                    n_k     = 5'd0;
                    n_state = S_E_MUL;
                end else begin
                    n_acc = w_sum;
                    n_mon = r_mon + 4'd1;
                end
            end
            S_E_MUL: begin
                op_b  = w_src << w_term.shift;
                n_acc = w_sum;
                n_k   = r_k + 5'd1;
                if (r_k == MUL_LAST) begin
                    n_secs     = w_sum;
                    n_days     = 32'd0;
                    n_out_hour = 5'd0;
                    n_out_min  = 6'd0;
                    n_k        = DAY_BIT_TOP;
                    n_state    = S_D_DAY;
                end
            end
            S_D_DAY: begin
                op_b   = SEC_PER_DAY << r_k;
                op_sub = 1'b1;
                if (!w_borrow) begin
                    n_acc        = w_sum;
                    n_days[r_k]  = 1'b1;
                end
                n_k = r_k - 5'd1;
                if (r_k == 5'd0) begin
                    n_k     = HOUR_BIT_TOP;
                    n_state = S_D_HOUR;
                end
            end
            S_D_HOUR: begin
                op_b   = SEC_PER_HOUR << r_k;
                op_sub = 1'b1;
                if (!w_borrow) begin
                    n_acc                  = w_sum;
                    n_out_hour[r_k[2:0]]   = 1'b1;
                end
                n_k = r_k - 5'd1;
                if (r_k == 5'd0) begin
                    n_k     = MIN_BIT_TOP;
                    n_state = S_D_MIN;
                end
            end
            S_D_MIN: begin
                op_b   = SEC_PER_MIN << r_k;
                op_sub = 1'b1;
                if (!w_borrow) begin
                    n_acc                 = w_sum;
                    n_out_min[r_k[2:0]]   = 1'b1;
                end
                n_k = r_k - 5'd1;
                if (r_k == 5'd0) begin
                    n_state = S_D_WOFF;
                end
            end
            S_D_WOFF: begin
                n_out_sec = r_acc[5:0];
                op_a      = r_days;
                op_b      = WEEK_OFFSET;
                n_acc     = w_sum;
                n_k       = WEEK_BIT_TOP;
                n_state   = S_D_WMOD;
            end
            S_D_WMOD: begin
                op_b   = DAYS_PER_WEEK << r_k;
                op_sub = 1'b1;
                if (!w_borrow) begin
                    n_acc = w_sum;
                end
                n_k = r_k - 5'd1;
                if (r_k == 5'd0) begin
                    n_cnt   = 8'd0;
                    n_state = S_D_YEAR;
                end
            end
            S_D_YEAR: begin
                op_a   = r_days;
                op_b   = (r_cnt[1:0] == 2'd0) ? DAYS_LEAP : DAYS_COMMON;
                op_sub = 1'b1;
                if (w_borrow) begin
                    n_mon   = 4'd1;
                    n_state = S_D_MONTH;
                end else begin
                    n_days = w_sum;
                    n_cnt  = r_cnt + 8'd1;
                end
            end
            S_D_MONTH: begin
                op_a   = r_days;
                op_b   = {27'd0, month_days(r_mon, r_cnt)};
                op_sub = 1'b1;
                if (r_mon == LAST_MONTH || w_borrow) begin
                    n_state = S_DONE;
                end else begin
                    n_days = w_sum;
                    n_mon  = r_mon + 4'd1;
                end
            end
            S_DONE: begin
                o_result.done                  = 1'b1;
                o_result.rsp.out_epoch_seconds = r_secs;
                o_result.rsp.out_second        = r_out_sec;
                o_result.rsp.out_minute        = r_out_min;
                o_result.rsp.out_hour          = r_out_hour;
                o_result.rsp.out_weekday       = r_acc[2:0] + 3'd1;
                o_result.rsp.out_day_of_month  = r_days[4:0] + 5'd1;
                o_result.rsp.out_month         = r_mon;
                o_result.rsp.out_year          = r_cnt;
                n_state                        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: rtl/calendar_epoch_converter.sv
// Top level of the calendar and epoch-seconds converter.
// A transaction is taken when start is high and busy is low; busy then stays high until the
// result is ready; the result appears on o_result with o_strobe high for exactly one cycle,
// with no way to hold it off, and o_result then holds it until the next result. All work runs
// through one shared 32-bit add/subtract unit, one step per cycle. Seconds to fields
// (request 1) decodes days, hours and minutes bit by bit, then the weekday, then the year
// since 2000 and the month. Fields to seconds and adding seconds (requests 0 and 2) first sum
// the days of each input year and month (month 0 is taken as month 1), then run the same decode.
// The result strobe comes in the first cycle with busy low, when the next transaction may
// already be taken. Request type 3 is taken and gives no result.
module calendar_epoch_converter import cec_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_cec_req i_req,
    output logic     o_strobe,
    output t_cec_rsp o_result
);

    logic        w_busy;
    logic        w_take;
    t_cec_result w_result;
    logic        r_strobe;
    t_cec_rsp    r_result;

    assign w_take = start & ~w_busy;

    cec_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_take),
        .i_req    (i_req),
        .o_busy   (w_busy),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_result.done;
        end
        if (w_result.done) begin
            r_result <= w_result.rsp;
        end
    end

    assign busy     = w_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

FILE: rtl/cec_checker.sv
// Port-level assertions for the converter, bound to the top level.
module cec_checker import cec_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input t_cec_req i_req,
    input logic     o_strobe,
    input t_cec_rsp o_result
);

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    a_take_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.req_type != REQ_NONE) |=> busy)
        else $error("transaction taken without raising busy");

    a_none_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.req_type == REQ_NONE) |=> (!busy && !o_strobe))
        else $error("unused request type started work");

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (!busy && $past(busy)))
        else $error("result strobe not at the end of a busy period");

    a_fields_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.out_second < 6'd60 && o_result.out_minute < 6'd60
                      && o_result.out_hour < 5'd24 && o_result.out_weekday != 3'd0
                      && o_result.out_month != 4'd0 && o_result.out_month <= 4'd12
                      && o_result.out_day_of_month != 5'd0))
        else $error("decoded calendar field out of range");

endmodule

bind calendar_epoch_converter cec_checker u_cec_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_req    (i_req),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

FILE: dv/calendar_epoch_converter_test.sv
// Self-checking testbench of the calendar and epoch-seconds converter, directed table then random.
`timescale 1ns / 1ps

module calendar_epoch_converter_test;
    import cec_pkg::*;

    localparam int RANDOM_ITEMS   = 950;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int SETTLE_CYCLES  = 800;

    typedef struct {
        t_cec_req req;
        bit       known;
        t_cec_rsp rsp;
    } t_vector_row;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_cec_req i_req;
    logic     o_strobe;
    t_cec_rsp o_result;

    logic     row_known;
    t_cec_rsp row_rsp;

    t_cec_rsp    pending_rsp_q[$];
    t_vector_row vector_table[$];
    int          error_count = 0;
    int          idle_cycles = 0;

    calendar_epoch_converter i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [31:0] month_length(input int mon, input int year);
        if (mon == 2) begin
            return ((year % 4) == 0) ? 32'd29 : 32'd28;
        end
        if (mon == 4 || mon == 6 || mon == 9 || mon == 11) begin
            return 32'd30;
        end
        if (mon >= 1 && mon <= 12) begin
            return 32'd31;
        end
        return 32'd0;
    endfunction

    function automatic logic [31:0] year_length(input int year);
        return ((year % 4) == 0) ? DAYS_LEAP : DAYS_COMMON;
    endfunction

    function automatic logic [31:0] seconds_of_fields(input t_cec_req q);
        logic [31:0] day_count;
        day_count = 32'd0;
        for (int k = 0; k < int'(q.in_year); k++) begin
            day_count += year_length(k);
        end
        for (int k = 1; k < int'(q.in_month); k++) begin
            day_count += month_length(k, int'(q.in_year));
        end
        day_count += {27'd0, q.in_day_of_month} - 32'd1;
        return day_count * SEC_PER_DAY + {27'd0, q.in_hour} * SEC_PER_HOUR
            + {26'd0, q.in_minute} * SEC_PER_MIN + {26'd0, q.in_second};
    endfunction

    function automatic t_cec_rsp calendar_of_seconds(input logic [31:0] secs);
        t_cec_rsp    r;
        logic [31:0] day_count;
        logic [31:0] rem;
        int          yr;
        int          mon;
        day_count = secs / SEC_PER_DAY;
        rem = secs % SEC_PER_DAY;
        r.out_epoch_seconds = secs;
        r.out_hour = 5'(rem / SEC_PER_HOUR);
        rem = rem % SEC_PER_HOUR;
        r.out_minute = 6'(rem / SEC_PER_MIN);
        r.out_second = 6'(rem % SEC_PER_MIN);
        r.out_weekday = 3'((WEEK_OFFSET + day_count) % DAYS_PER_WEEK + 32'd1);
        yr = 0;
        while (day_count >= year_length(yr)) begin
            day_count -= year_length(yr);
            yr++;
        end
        mon = 1;
        while (mon < 12 && day_count >= month_length(mon, yr)) begin
            day_count -= month_length(mon, yr);
            mon++;
        end
        r.out_day_of_month = 5'(day_count + 32'd1);
        r.out_month = 4'(mon);
        r.out_year = 8'(yr);
        return r;
    endfunction

    function automatic bit predict_conversion(input t_cec_req q, output t_cec_rsp r);
        r = '0;
        case (t_req_code'(q.req_type))
            REQ_TO_SECONDS: begin
                r = calendar_of_seconds(seconds_of_fields(q));
                return 1'b1;
            end
            REQ_TO_FIELDS: begin
                r = calendar_of_seconds(q.in_seconds);
                return 1'b1;
            end
            REQ_ADD_SECONDS: begin
                r = calendar_of_seconds(seconds_of_fields(q) + q.in_seconds);
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    function automatic string diff_fields(input t_cec_rsp e, input t_cec_rsp a);
        string s;
        s = "";
        if (e.out_epoch_seconds !== a.out_epoch_seconds) s = {s, " epoch_seconds"};
        if (e.out_second !== a.out_second) s = {s, " second"};
        if (e.out_minute !== a.out_minute) s = {s, " minute"};
        if (e.out_hour !== a.out_hour) s = {s, " hour"};
        if (e.out_weekday !== a.out_weekday) s = {s, " weekday"};
        if (e.out_day_of_month !== a.out_day_of_month) s = {s, " day_of_month"};
        if (e.out_month !== a.out_month) s = {s, " month"};
        if (e.out_year !== a.out_year) s = {s, " year"};
        return s;
    endfunction

    function automatic t_cec_req mk_req(input t_req_code code, input int sec, input int min,
                                        input int hr, input int dom, input int mon,
                                        input int yr, input logic [31:0] secs);
        t_cec_req q;
        q.req_type = code;
        q.in_second = 6'(sec);
        q.in_minute = 6'(min);
        q.in_hour = 5'(hr);
        q.in_day_of_month = 5'(dom);
        q.in_month = 4'(mon);
        q.in_year = 8'(yr);
        q.in_seconds = secs;
        return q;
    endfunction

    function automatic t_cec_req random_request();
        t_cec_req    q;
        logic [95:0] raw;
        int          pick;
        raw = {$urandom, $urandom, $urandom};
        q = raw[67:0];
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            if (pick < 28) begin
                q.req_type = REQ_TO_SECONDS;
            end else if (pick < 56) begin
                q.req_type = REQ_TO_FIELDS;
            end else begin
                q.req_type = REQ_ADD_SECONDS;
            end
            q.in_second = 6'($urandom_range(0, 59));
            q.in_minute = 6'($urandom_range(0, 59));
            q.in_hour = 5'($urandom_range(0, 23));
            q.in_month = 4'($urandom_range(1, 12));
            q.in_year = 8'($urandom_range(0, 136));
            q.in_day_of_month = 5'($urandom_range(1, month_length(int'(q.in_month),
                                                                 int'(q.in_year))));
            if ($urandom_range(0, 3) == 0) begin
                q.in_seconds = $urandom_range(0, 200000);
            end
        end else if (pick < 90) begin
            q.req_type = REQ_NONE;
        end
        return q;
    endfunction

    task automatic send_transaction(input t_cec_req q, input bit known, input t_cec_rsp rsp,
                                    input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            if ($urandom_range(0, 1) == 1) begin
                do @(posedge i_clk); while (busy);
            end
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= q;
        row_known <= known;
        row_rsp <= rsp;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : monitor
        t_cec_rsp want;
        string    bad;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (pending_rsp_q.size() == 0) begin
                    if (error_count < 10) begin
                        $display("unexpected result: epoch %0d", o_result.out_epoch_seconds);
                    end
                    error_count++;
                end else begin
                    want = pending_rsp_q.pop_front();
                    bad = diff_fields(want, o_result);
                    if (bad != "") begin
                        if (error_count < 10) begin
                            $display("mismatch on%s: expected %0d %0d:%0d:%0d wd %0d %0d/%0d/%0d",
                                bad, want.out_epoch_seconds, want.out_hour, want.out_minute,
                                want.out_second, want.out_weekday, want.out_year,
                                want.out_month, want.out_day_of_month);
                            $display("    actual %0d %0d:%0d:%0d wd %0d %0d/%0d/%0d",
                                o_result.out_epoch_seconds, o_result.out_hour,
                                o_result.out_minute, o_result.out_second,
                                o_result.out_weekday, o_result.out_year,
                                o_result.out_month, o_result.out_day_of_month);
                        end
                        error_count++;
                    end
                end
            end
            if (start && !busy) begin
                if (row_known) begin
                    pending_rsp_q.push_back(row_rsp);
                end else if (predict_conversion(i_req, want)) begin
                    pending_rsp_q.push_back(want);
                end
            end
            if (o_strobe || (start && !busy)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("calendar_epoch_converter_test failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        t_cec_rsp epoch_rsp;
        int       burst_left;
        int       gap;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        row_known = 1'b0;
        row_rsp = '0;
        burst_left = 0;
        epoch_rsp = '{32'd0, 6'd0, 6'd0, 5'd0, 3'd6, 5'd1, 4'd1, 8'd0};

        vector_table.push_back('{mk_req(REQ_TO_SECONDS, 0, 0, 0, 1, 1, 0, 0), 1'b1, epoch_rsp});
        vector_table.push_back('{mk_req(REQ_TO_FIELDS, 0, 0, 0, 1, 1, 0, 0), 1'b1, epoch_rsp});
        vector_table.push_back('{mk_req(REQ_TO_FIELDS, 0, 0, 0, 1, 1, 0, 32'd86399), 1'b1,
                                 '{32'd86399, 6'd59, 6'd59, 5'd23, 3'd6, 5'd1, 4'd1, 8'd0}});
        vector_table.push_back('{mk_req(REQ_TO_FIELDS, 0, 0, 0, 1, 1, 0, 32'd86400), 1'b1,
                                 '{32'd86400, 6'd0, 6'd0, 5'd0, 3'd7, 5'd2, 4'd1, 8'd0}});
        vector_table.push_back('{mk_req(REQ_TO_FIELDS, 0, 0, 0, 1, 1, 0, 32'hFFFF_FFFF), 1'b1,
                                 '{32'hFFFF_FFFF, 6'd15, 6'd28, 5'd6, 3'd2, 5'd6, 4'd2, 8'd136}});
        vector_table.push_back('{mk_req(REQ_TO_SECONDS, 59, 59, 23, 31, 12, 136, 32'hFFFF_FFFF),
                                 1'b0, '0});
        vector_table.push_back('{mk_req(REQ_TO_SECONDS, 63, 63, 31, 31, 15, 255, 32'hFFFF_FFFF),
                                 1'b0, '0});
        vector_table.push_back('{mk_req(REQ_TO_SECONDS, 1, 2, 3, 5, 0, 3, 0), 1'b0, '0});
        vector_table.push_back('{mk_req(REQ_TO_SECONDS, 0, 0, 0, 1, 13, 1, 0), 1'b0, '0});
        vector_table.push_back('{mk_req(REQ_TO_SECONDS, 0, 0, 0, 1, 14, 2, 0), 1'b0, '0});
        vector_table.push_back('{mk_req(REQ_TO_SECONDS, 0, 0, 0, 1, 15, 4, 0), 1'b0, '0});
        vector_table.push_back('{mk_req(REQ_TO_SECONDS, 0, 0, 0, 0, 1, 0, 0), 1'b0, '0});
        vector_table.push_back('{mk_req(REQ_TO_SECONDS, 7, 8, 9, 0, 3, 10, 0), 1'b0, '0});
        vector_table.push_back('{mk_req(REQ_ADD_SECONDS, 45, 30, 12, 29, 2, 4, 0), 1'b0, '0});
        vector_table.push_back('{mk_req(REQ_ADD_SECONDS, 59, 59, 23, 31, 12, 3, 1), 1'b0, '0});
        vector_table.push_back('{mk_req(REQ_ADD_SECONDS, 0, 0, 0, 1, 1, 0, 32'hFFFF_FFFF),
                                 1'b0, '0});
        vector_table.push_back('{mk_req(REQ_ADD_SECONDS, 0, 0, 0, 31, 12, 136, 32'h8000_0000),
                                 1'b0, '0});
        vector_table.push_back('{mk_req(REQ_NONE, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        vector_table.push_back('{mk_req(REQ_NONE, 63, 63, 31, 31, 15, 255, 32'hFFFF_FFFF),
                                 1'b0, '0});
        vector_table.push_back('{mk_req(REQ_TO_FIELDS, 63, 63, 31, 31, 15, 255, 32'd5097600),
                                 1'b0, '0});
        vector_table.push_back('{mk_req(REQ_TO_FIELDS, 0, 0, 0, 1, 1, 0, 32'd31622400),
                                 1'b0, '0});
        vector_table.push_back('{mk_req(REQ_ADD_SECONDS, 63, 63, 31, 15, 6, 20, 32'd12345),
                                 1'b0, '0});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (vector_table[n]) begin
            send_transaction(vector_table[n].req, vector_table[n].known, vector_table[n].rsp,
                             $urandom_range(0, 8));
        end
        wait_for_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                wait_for_results();
            end
            if (burst_left == 0 && $urandom_range(0, 15) == 0) begin
                burst_left = $urandom_range(10, 30);
            end
            if (burst_left > 0) begin
                gap = 0;
                burst_left--;
            end else begin
                gap = $urandom_range(0, 8);
            end
            send_transaction(random_request(), 1'b0, '0, gap);
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_rsp_q.size() == 0) begin
            $display("calendar_epoch_converter_test passed");
        end else begin
            $display("calendar_epoch_converter_test failed");
        end
        $finish;
    end

endmodule
